[src/assert_macros.svh]
// Assertion macros used by the checker in dlcd_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define DLCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define DLCD_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/dlcd_pkg.sv]
// Shared constants and types for the double line crossing detector.
// No dependencies.
package dlcd_pkg;

   localparam int REG_ADDR_WIDTH    = 3;
   localparam int NUM_REGS          = 8;
   localparam int POINT_COUNT_WIDTH = 10;
   localparam int MIN_POINTS        = 3;

   // Tests run side by side, indexed by these.
   localparam int TEST_EXIT  = 0;
   localparam int TEST_ENTRY = 1;
   localparam int NUM_TESTS  = 2;

   // Register stages from input transfer to result.
   localparam int PIPE_DEPTH     = 4;
   localparam int PIPE_CNT_WIDTH = 3;

   typedef enum logic [REG_ADDR_WIDTH-1:0] {
      REG_ENTRY_START_X = 3'd0,
      REG_ENTRY_START_Y = 3'd1,
      REG_ENTRY_END_X   = 3'd2,
      REG_ENTRY_END_Y   = 3'd3,
      REG_EXIT_START_X  = 3'd4,
      REG_EXIT_START_Y  = 3'd5,
      REG_EXIT_END_X    = 3'd6,
      REG_EXIT_END_Y    = 3'd7
   } reg_index_type;

endpackage

[src/double_line_crossing_detector_core.sv]
// Double line crossing detector: per-track segment tests against an exit and an entry line.
// Depends on dlcd_pkg.
//
// One track is taken per clock cycle while the pipeline is not stalled; its result passes the
// difference, product, cross-product and compare registers before it is offered on rsp_tvalid.
// Each stage holds only when the stage after it is full and stalled, so bubbles are squeezed out
// and a stalled result still lets new tracks enter until the pipeline is full. Twelve signed
// (COORD_WIDTH+1)-bit multipliers in the second stage set the critical path.
module double_line_crossing_detector_core #(
   parameter int COORD_WIDTH       = 16,
   parameter int FRAC_BITS         = 4,
   parameter int TRACK_INDEX_WIDTH = 8,
   localparam int REQ_DATA_WIDTH   =
      ((TRACK_INDEX_WIDTH + 4 * COORD_WIDTH + dlcd_pkg::POINT_COUNT_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH   = ((TRACK_INDEX_WIDTH + 1 + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // track_number, first_x, first_y, latest_x, latest_y, point_count
   input  logic [REQ_DATA_WIDTH-1:0]            req_tdata,
   // already_caught
   input  logic [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // track_echo, crossed_both
   output logic [RSP_DATA_WIDTH-1:0]            rsp_tdata,
   input  logic                                 csr_we,
   input  logic [dlcd_pkg::REG_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [COORD_WIDTH-1:0]               csr_wdata
);
   import dlcd_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int CW = SW + 1;
   localparam int TIW = TRACK_INDEX_WIDTH;
   localparam int EPS_UNITS = ((1 << (2 * FRAC_BITS)) + 99) / 100;
   localparam logic signed [CW-1:0] EPS_C = CW'(EPS_UNITS);

   function automatic logic seg_pass(input logic signed [SW-1:0] c,
                                     input logic signed [SW-1:0] n1,
                                     input logic signed [SW-1:0] n2,
                                     input logic is_entry);
      logic signed [CW-1:0] ce;
      logic signed [CW-1:0] n1e;
      logic signed [CW-1:0] n2e;
      logic pos;
      logic near;
      logic r1;
      logic r2;
      ce   = CW'(c);
      n1e  = CW'(n1);
      n2e  = CW'(n2);
      pos  = (c > 0);
      near = ((ce - EPS_C) < 0) && ((ce + EPS_C) > 0);
      if (pos) begin
         r1 = (n1 >= 0) && ((ce - n1e) >= 0);
      end else begin
         r1 = (n1 <= 0) && ((n1e - ce) >= 0);
      end
      if (is_entry) begin
         r2 = pos ? (n2 <= 0) : (n2 >= 0);
      end else if (pos) begin
         r2 = (n2 >= 0) && ((ce - n2e) >= 0);
      end else begin
         r2 = (n2 <= 0) && ((n2e - ce) >= 0);
      end
      return !near && r1 && r2;
   endfunction

   // configuration
   logic signed [COORD_WIDTH-1:0] cfg_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         cfg_ff[csr_addr] <= csr_wdata;
      end
   end

   // stage control
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage 1: differences
   logic signed [COORD_WIDTH-1:0] fx, fy, lx, ly;
   logic [POINT_COUNT_WIDTH-1:0]  count;
   logic signed [COORD_WIDTH-1:0] ls_x [NUM_TESTS];
   logic signed [COORD_WIDTH-1:0] ls_y [NUM_TESTS];
   logic signed [COORD_WIDTH-1:0] le_x [NUM_TESTS];
   logic signed [COORD_WIDTH-1:0] le_y [NUM_TESTS];

   logic [TIW-1:0]         track1_in, track1_ff;
   logic                   qual1_in, qual1_ff;
   logic signed [DW-1:0]   xx_in [NUM_TESTS];
   logic signed [DW-1:0]   xx_ff [NUM_TESTS];
   logic signed [DW-1:0]   xy_in [NUM_TESTS];
   logic signed [DW-1:0]   xy_ff [NUM_TESTS];
   logic signed [DW-1:0]   d1x_in [NUM_TESTS];
   logic signed [DW-1:0]   d1x_ff [NUM_TESTS];
   logic signed [DW-1:0]   d1y_in [NUM_TESTS];
   logic signed [DW-1:0]   d1y_ff [NUM_TESTS];
   logic signed [DW-1:0]   d2x_in, d2x_ff;
   logic signed [DW-1:0]   d2y_in, d2y_ff;

   always_comb begin
      fx    = req_tdata[TIW +: COORD_WIDTH];
      fy    = req_tdata[TIW + COORD_WIDTH +: COORD_WIDTH];
      lx    = req_tdata[TIW + 2 * COORD_WIDTH +: COORD_WIDTH];
      ly    = req_tdata[TIW + 3 * COORD_WIDTH +: COORD_WIDTH];
      count = req_tdata[TIW + 4 * COORD_WIDTH +: POINT_COUNT_WIDTH];

      ls_x[TEST_EXIT]  = cfg_ff[REG_EXIT_START_X];
      ls_y[TEST_EXIT]  = cfg_ff[REG_EXIT_START_Y];
      le_x[TEST_EXIT]  = cfg_ff[REG_EXIT_END_X];
      le_y[TEST_EXIT]  = cfg_ff[REG_EXIT_END_Y];
      ls_x[TEST_ENTRY] = cfg_ff[REG_ENTRY_START_X];
      ls_y[TEST_ENTRY] = cfg_ff[REG_ENTRY_START_Y];
      le_x[TEST_ENTRY] = cfg_ff[REG_ENTRY_END_X];
      le_y[TEST_ENTRY] = cfg_ff[REG_ENTRY_END_Y];

      track1_in = req_tdata[TIW-1:0];
      qual1_in  = !req_tuser[0] && (count >= POINT_COUNT_WIDTH'(MIN_POINTS));
      d2x_in    = DW'(lx) - DW'(fx);
      d2y_in    = DW'(ly) - DW'(fy);
      for (int t = 0; t < NUM_TESTS; t++) begin
         xx_in[t]  = DW'(fx) - DW'(ls_x[t]);
         xy_in[t]  = DW'(fy) - DW'(ls_y[t]);
         d1x_in[t] = DW'(le_x[t]) - DW'(ls_x[t]);
         d1y_in[t] = DW'(le_y[t]) - DW'(ls_y[t]);
      end
   end

   // stage 2: products
   logic [TIW-1:0]       track2_ff;
   logic                 qual2_ff;
   logic signed [PW-1:0] pc1_in [NUM_TESTS];
   logic signed [PW-1:0] pc1_ff [NUM_TESTS];
   logic signed [PW-1:0] pc2_in [NUM_TESTS];
   logic signed [PW-1:0] pc2_ff [NUM_TESTS];
   logic signed [PW-1:0] pn1a_in [NUM_TESTS];
   logic signed [PW-1:0] pn1a_ff [NUM_TESTS];
   logic signed [PW-1:0] pn1b_in [NUM_TESTS];
   logic signed [PW-1:0] pn1b_ff [NUM_TESTS];
   logic signed [PW-1:0] pn2a_in [NUM_TESTS];
   logic signed [PW-1:0] pn2a_ff [NUM_TESTS];
   logic signed [PW-1:0] pn2b_in [NUM_TESTS];
   logic signed [PW-1:0] pn2b_ff [NUM_TESTS];

   always_comb begin
      for (int t = 0; t < NUM_TESTS; t++) begin
         pc1_in[t]  = d1x_ff[t] * d2y_ff;
         pc2_in[t]  = d1y_ff[t] * d2x_ff;
         pn1a_in[t] = xx_ff[t] * d2y_ff;
         pn1b_in[t] = xy_ff[t] * d2x_ff;
         pn2a_in[t] = xx_ff[t] * d1y_ff[t];
         pn2b_in[t] = xy_ff[t] * d1x_ff[t];
      end
   end

   // stage 3: cross products
   logic [TIW-1:0]       track3_ff;
   logic                 qual3_ff;
   logic signed [SW-1:0] c_in [NUM_TESTS];
   logic signed [SW-1:0] c_ff [NUM_TESTS];
   logic signed [SW-1:0] n1_in [NUM_TESTS];
   logic signed [SW-1:0] n1_ff [NUM_TESTS];
   logic signed [SW-1:0] n2_in [NUM_TESTS];
   logic signed [SW-1:0] n2_ff [NUM_TESTS];

   always_comb begin
      for (int t = 0; t < NUM_TESTS; t++) begin
         c_in[t]  = SW'(pc1_ff[t]) - SW'(pc2_ff[t]);
         n1_in[t] = SW'(pn1a_ff[t]) - SW'(pn1b_ff[t]);
         n2_in[t] = SW'(pn2a_ff[t]) - SW'(pn2b_ff[t]);
      end
   end

   // stage 4: compares
   logic [TIW-1:0] track4_ff;
   logic           crossed4_in, crossed4_ff;

   always_comb begin
      crossed4_in = qual3_ff
         && seg_pass(c_ff[TEST_EXIT], n1_ff[TEST_EXIT], n2_ff[TEST_EXIT], 1'b0)
         && seg_pass(c_ff[TEST_ENTRY], n1_ff[TEST_ENTRY], n2_ff[TEST_ENTRY], 1'b1);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         track1_ff <= track1_in;
         qual1_ff  <= qual1_in;
         d2x_ff    <= d2x_in;
         d2y_ff    <= d2y_in;
         for (int t = 0; t < NUM_TESTS; t++) begin
            xx_ff[t]  <= xx_in[t];
            xy_ff[t]  <= xy_in[t];
            d1x_ff[t] <= d1x_in[t];
            d1y_ff[t] <= d1y_in[t];
         end
      end
      if (en2) begin
         track2_ff <= track1_ff;
         qual2_ff  <= qual1_ff;
         for (int t = 0; t < NUM_TESTS; t++) begin
            pc1_ff[t]  <= pc1_in[t];
            pc2_ff[t]  <= pc2_in[t];
            pn1a_ff[t] <= pn1a_in[t];
            pn1b_ff[t] <= pn1b_in[t];
            pn2a_ff[t] <= pn2a_in[t];
            pn2b_ff[t] <= pn2b_in[t];
         end
      end
      if (en3) begin
         track3_ff <= track2_ff;
         qual3_ff  <= qual2_ff;
         for (int t = 0; t < NUM_TESTS; t++) begin
            c_ff[t]  <= c_in[t];
            n1_ff[t] <= n1_in[t];
            n2_ff[t] <= n2_in[t];
         end
      end
      if (en4) begin
         track4_ff   <= track3_ff;
         crossed4_ff <= crossed4_in;
      end
   end

   assign rsp_tvalid = v4_ff;

   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[TIW-1:0] = track4_ff;
      rsp_tdata[TIW]     = crossed4_ff;
   end

endmodule

[src/dlcd_checker.sv]
// Port-level checker for double_line_crossing_detector_core, with its bind.
// Depends on dlcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlcd_checker #(
   parameter int RSP_W = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);
   import dlcd_pkg::*;

   logic [PIPE_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic in_xfer, out_xfer;

   assign in_xfer  = req_tvalid && req_tready;
   assign out_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in = cnt_ff;
      if (in_xfer && !out_xfer) begin
         cnt_in = cnt_ff + PIPE_CNT_WIDTH'(1);
      end else if (out_xfer && !in_xfer) begin
         cnt_in = cnt_ff - PIPE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `DLCD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `DLCD_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `DLCD_ASSERT(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready, "not ready with empty output")
   `DLCD_ASSERT(a_in_flight, clock, reset, cnt_ff <= PIPE_CNT_WIDTH'(PIPE_DEPTH), "too many tracks in flight")
   `DLCD_ASSERT(a_no_phantom, clock, reset, rsp_tvalid |-> cnt_ff != '0, "result without a track")

endmodule

bind double_line_crossing_detector_core dlcd_checker #(.RSP_W(RSP_DATA_WIDTH)) u_dlcd_checker (.*);

[test/dlcd_crossing_monitor.sv]
// Monitor for the double line crossing detector: watches the track, result and register ports,
// predicts the crossing verdict of every track transfer and compares it with the results.
// Depends on dlcd_pkg.
module dlcd_crossing_monitor #(
   parameter int COORD_WIDTH       = 16,
   parameter int FRAC_BITS         = 4,
   parameter int TRACK_INDEX_WIDTH = 8,
   localparam int REQ_DATA_WIDTH   =
      ((TRACK_INDEX_WIDTH + 4 * COORD_WIDTH + dlcd_pkg::POINT_COUNT_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH   = ((TRACK_INDEX_WIDTH + 1 + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // track_number, first_x, first_y, latest_x, latest_y, point_count
   input  logic [REQ_DATA_WIDTH-1:0]           req_tdata,
   // already_caught
   input  logic [0:0]                          req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // track_echo, crossed_both
   input  logic [RSP_DATA_WIDTH-1:0]           rsp_tdata,
   input  logic                                csr_we,
   input  logic [dlcd_pkg::REG_ADDR_WIDTH-1:0] csr_addr,
   input  logic [COORD_WIDTH-1:0]              csr_wdata,
   output int                                  mismatch_count,
   output int                                  verdicts_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import dlcd_pkg::*;

   localparam int FX_LSB = TRACK_INDEX_WIDTH;
   localparam int FY_LSB = FX_LSB + COORD_WIDTH;
   localparam int LX_LSB = FY_LSB + COORD_WIDTH;
   localparam int LY_LSB = LX_LSB + COORD_WIDTH;
   localparam int PC_LSB = LY_LSB + COORD_WIDTH;
   // parallel threshold of 0.01 square pixels in product units
   localparam longint PARALLEL_LIMIT = ((longint'(1) << (2 * FRAC_BITS)) + 99) / 100;

   typedef struct packed {
      logic [TRACK_INDEX_WIDTH-1:0] track_echo;
      logic                         crossed_both;
   } crossing_verdict_type;

   crossing_verdict_type          pending_verdicts [$];
   logic signed [COORD_WIDTH-1:0] line_reg [NUM_REGS];
   int                            fail_tally = 0;

   function automatic bit param_in_unit(longint num, longint den);
      if (den > 0) begin
         return num >= 0 && den - num >= 0;
      end
      return num <= 0 && num - den >= 0;
   endfunction

   // Segment a against segment b. With behind_start the parameter on b must be at most 0
   // instead of lying in [0,1].
   function automatic bit segments_meet(longint a0x, longint a0y, longint a1x, longint a1y,
                                        longint b0x, longint b0y, longint b1x, longint b1y,
                                        bit behind_start);
      longint ox, oy, dax, day, dbx, dby, den, num_a, num_b;
      ox    = b0x - a0x;
      oy    = b0y - a0y;
      dax   = a1x - a0x;
      day   = a1y - a0y;
      dbx   = b1x - b0x;
      dby   = b1y - b0y;
      den   = dax * dby - day * dbx;
      num_a = ox * dby - oy * dbx;
      num_b = ox * day - oy * dax;
      if (den < PARALLEL_LIMIT && den > -PARALLEL_LIMIT) begin
         return 1'b0;
      end
      if (!param_in_unit(num_a, den)) begin
         return 1'b0;
      end
      if (!behind_start) begin
         return param_in_unit(num_b, den);
      end
      return den > 0 ? num_b <= 0 : num_b >= 0;
   endfunction

   function automatic bit track_crosses_both(logic signed [COORD_WIDTH-1:0] fx,
                                             logic signed [COORD_WIDTH-1:0] fy,
                                             logic signed [COORD_WIDTH-1:0] lx,
                                             logic signed [COORD_WIDTH-1:0] ly,
                                             logic [POINT_COUNT_WIDTH-1:0] count,
                                             logic caught);
      if (caught || count < MIN_POINTS) begin
         return 1'b0;
      end
      if (!segments_meet(line_reg[REG_EXIT_START_X], line_reg[REG_EXIT_START_Y],
                         line_reg[REG_EXIT_END_X], line_reg[REG_EXIT_END_Y],
                         fx, fy, lx, ly, 1'b0)) begin
         return 1'b0;
      end
      return segments_meet(line_reg[REG_ENTRY_START_X], line_reg[REG_ENTRY_START_Y],
                           line_reg[REG_ENTRY_END_X], line_reg[REG_ENTRY_END_Y],
                           fx, fy, lx, ly, 1'b1);
   endfunction

   always @(posedge clock) begin
      crossing_verdict_type predicted, observed;
      int r;
      if (reset) begin
         for (r = 0; r < NUM_REGS; r++) begin
            line_reg[r] = '0;
         end
         pending_verdicts.delete();
      end else begin
         if (csr_we) begin
            line_reg[csr_addr] = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            predicted.track_echo   = req_tdata[TRACK_INDEX_WIDTH-1:0];
            predicted.crossed_both = track_crosses_both(req_tdata[FX_LSB +: COORD_WIDTH],
                                                        req_tdata[FY_LSB +: COORD_WIDTH],
                                                        req_tdata[LX_LSB +: COORD_WIDTH],
                                                        req_tdata[LY_LSB +: COORD_WIDTH],
                                                        req_tdata[PC_LSB +: POINT_COUNT_WIDTH],
                                                        req_tuser[0]);
            pending_verdicts = {pending_verdicts, predicted};
         end
         if (rsp_tvalid && rsp_tready) begin
            observed.track_echo   = rsp_tdata[TRACK_INDEX_WIDTH-1:0];
            observed.crossed_both = rsp_tdata[TRACK_INDEX_WIDTH];
            if (pending_verdicts.size() == 0) begin
               $display("%0t: result transfer with none expected: track_echo %0d crossed_both %0d",
                        $time, observed.track_echo, observed.crossed_both);
               fail_tally++;
            end else begin
               predicted = pending_verdicts.pop_front();
               if (observed.track_echo !== predicted.track_echo) begin
                  $display("%0t: track_echo expected %0d, actual %0d",
                           $time, predicted.track_echo, observed.track_echo);
                  fail_tally++;
               end
               if (observed.crossed_both !== predicted.crossed_both) begin
                  $display("%0t: crossed_both of track %0d expected %0d, actual %0d",
                           $time, predicted.track_echo, predicted.crossed_both,
                           observed.crossed_both);
                  fail_tally++;
               end
            end
         end
      end
      verdicts_pending <= pending_verdicts.size();
      mismatch_count   <= fail_tally;
   end

endmodule

[test/tb_double_line_crossing_detector_core.sv]
// Testbench top for double_line_crossing_detector_core: clock, reset, line register setup,
// directed and random track stimulus with bursty sender and stalling receiver, verdict.
// Depends on dlcd_pkg, the core and dlcd_crossing_monitor.
module tb_double_line_crossing_detector_core;
   timeunit 1ns;
   timeprecision 1ps;

   import dlcd_pkg::*;

   localparam int COORD_W      = 16;
   localparam int FRAC_W       = 4;
   localparam int TRACK_W      = 8;
   localparam int REQ_W        = ((TRACK_W + 4 * COORD_W + POINT_COUNT_WIDTH + 7) / 8) * 8;
   localparam int RSP_W        = ((TRACK_W + 1 + 7) / 8) * 8;
   localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));
   localparam int FULL_SPAN    = 1 << (COORD_W - 1);
   localparam int HOLD_CYCLES  = 120;
   localparam int IDLE_LIMIT   = 1000;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic [REQ_W-1:0]          req_tdata  = '0;
   logic [0:0]                req_tuser  = '0;
   logic                      rsp_tready = 1'b0;
   logic                      csr_we     = 1'b0;
   logic [REG_ADDR_WIDTH-1:0] csr_addr   = REG_ENTRY_START_X;
   logic [COORD_W-1:0]        csr_wdata  = '0;
   logic                      req_tready;
   logic                      rsp_tvalid;
   logic [RSP_W-1:0]          rsp_tdata;
   int                        mismatch_count;
   int                        verdicts_pending;

   logic signed [COORD_W-1:0] line_cfg [NUM_REGS];
   int                        burst_left  = 0;
   int                        idle_cycles = 0;
   bit                        hold_wanted = 1'b0;
   bit                        hold_done   = 1'b0;

   always #2 clock = ~clock;

   double_line_crossing_detector_core #(
      .COORD_WIDTH      (COORD_W),
      .FRAC_BITS        (FRAC_W),
      .TRACK_INDEX_WIDTH(TRACK_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   dlcd_crossing_monitor #(
      .COORD_WIDTH      (COORD_W),
      .FRAC_BITS        (FRAC_W),
      .TRACK_INDEX_WIDTH(TRACK_W)
   ) u_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .verdicts_pending(verdicts_pending)
   );

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: rotating stall patterns, plus one long hold-off on request
   initial begin
      int rx_cycle;
      rx_cycle = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_wanted && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            case ((rx_cycle / 97) % 4)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= ($urandom_range(0, 1) == 1);
               end
               2: begin
                  rsp_tready <= (rx_cycle % 5 == 0);
               end
               default: begin
                  rsp_tready <= ($urandom_range(0, 9) != 0);
               end
            endcase
            rx_cycle++;
            @(posedge clock);
         end
      end
   end

   function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v > COORD_MAX) begin
         return COORD_MAX[COORD_W-1:0];
      end
      if (v < COORD_MIN) begin
         return COORD_MIN[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord(int span);
      return clamp_coord(longint'($urandom_range(0, 2 * span - 1)) - span);
   endfunction

   // one track transfer; afterwards either stay in the burst or drop valid for a gap
   task automatic offer_track(input logic [TRACK_W-1:0] num,
                              input logic signed [COORD_W-1:0] fx, fy, lx, ly,
                              input logic [POINT_COUNT_WIDTH-1:0] count,
                              input logic caught);
      req_tvalid <= 1'b1;
      req_tdata  <= {count, ly, lx, fy, fx, num};
      req_tuser  <= caught;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // track on the line from a point of the entry segment through a point of the exit
   // segment, starting between them and ending at or beyond the exit
   task automatic offer_aimed_track();
      longint px, py, qx, qy;
      int ta, tb;
      logic [POINT_COUNT_WIDTH-1:0] count;
      px = line_cfg[REG_ENTRY_START_X];
      py = line_cfg[REG_ENTRY_START_Y];
      qx = line_cfg[REG_EXIT_START_X];
      qy = line_cfg[REG_EXIT_START_Y];
      ta = $urandom_range(0, 16);
      px = px + (longint'(line_cfg[REG_ENTRY_END_X]) - px) * ta / 16;
      py = py + (longint'(line_cfg[REG_ENTRY_END_Y]) - py) * ta / 16;
      ta = $urandom_range(0, 16);
      qx = qx + (longint'(line_cfg[REG_EXIT_END_X]) - qx) * ta / 16;
      qy = qy + (longint'(line_cfg[REG_EXIT_END_Y]) - qy) * ta / 16;
      ta = $urandom_range(0, 16);
      tb = $urandom_range(16, 32);
      count = ($urandom_range(0, 7) == 0) ? POINT_COUNT_WIDTH'($urandom_range(0, 3))
                                          : POINT_COUNT_WIDTH'($urandom_range(3, 1023));
      offer_track(TRACK_W'($urandom_range(0, 255)),
                  clamp_coord(px + (qx - px) * ta / 16), clamp_coord(py + (qy - py) * ta / 16),
                  clamp_coord(px + (qx - px) * tb / 16), clamp_coord(py + (qy - py) * tb / 16),
                  count, $urandom_range(0, 9) == 0);
   endtask

   task automatic run_random(int n, int span);
      repeat (n) begin
         if ($urandom_range(0, 9) < 7) begin
            offer_aimed_track();
         end else begin
            offer_track(TRACK_W'($urandom_range(0, 255)), rand_coord(span), rand_coord(span),
                        rand_coord(span), rand_coord(span),
                        POINT_COUNT_WIDTH'($urandom_range(0, 1023)),
                        1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
   endtask

   task automatic program_lines();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= reg_index_type'(i);
         csr_wdata <= line_cfg[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic set_random_lines(int span);
      for (int i = 0; i < NUM_REGS; i++) begin
         line_cfg[i] = rand_coord(span);
      end
   endtask

   task automatic set_lines(longint nsx, nsy, nex, ney, xsx, xsy, xex, xey);
      line_cfg[REG_ENTRY_START_X] = clamp_coord(nsx);
      line_cfg[REG_ENTRY_START_Y] = clamp_coord(nsy);
      line_cfg[REG_ENTRY_END_X]   = clamp_coord(nex);
      line_cfg[REG_ENTRY_END_Y]   = clamp_coord(ney);
      line_cfg[REG_EXIT_START_X]  = clamp_coord(xsx);
      line_cfg[REG_EXIT_START_Y]  = clamp_coord(xsy);
      line_cfg[REG_EXIT_END_X]    = clamp_coord(xex);
      line_cfg[REG_EXIT_END_Y]    = clamp_coord(xey);
   endtask

   initial begin
      set_lines(0, 0, 0, 0, 0, 0, 0, 0);
      do @(posedge clock); while (reset);

      // lines still at reset: every pair degenerate
      run_random(30, FULL_SPAN);
      drain();

      // entry along y = 0, exit along y = 100 px, both x in [-100, 100] px
      set_lines(-1600, 0, 1600, 0, -1600, 1600, 1600, 1600);
      program_lines();
      offer_track(0, 0, 800, 0, 2400, 3, 1'b0);
      offer_track(1, 0, 800, 0, 2400, 2, 1'b0);
      offer_track(2, 0, 800, 0, 2400, 500, 1'b1);
      offer_track(3, 0, 800, 0, 2400, 0, 1'b0);
      offer_track(255, 0, 800, 0, 2400, 1023, 1'b0);
      offer_track(4, 0, 0, 0, 2400, 3, 1'b0);
      offer_track(5, 0, 800, 0, 1600, 3, 1'b0);
      offer_track(6, 1600, 800, 1600, 2400, 3, 1'b0);
      offer_track(7, 1601, 800, 1601, 2400, 3, 1'b0);
      offer_track(8, 0, 800, 0, 1500, 3, 1'b0);
      offer_track(9, 0, 2400, 0, 800, 3, 1'b0);
      offer_track(10, -100, 800, 100, 800, 3, 1'b0);
      offer_track(11, 0, -800, 0, 2400, 3, 1'b0);
      offer_track(12, -32768, -32768, 32767, 32767, 1023, 1'b0);
      offer_track(13, 32767, -32768, -32768, 32767, 3, 1'b0);
      offer_track(128, -1, -1, -1, -1, 1023, 1'b1);
      offer_track(170, -800, 800, 800, 2400, 3, 1'b0);
      drain();

      // unit-length lines: cross products of 2 and 3 sit either side of the threshold
      set_lines(0, -2, 1, -2, 0, 0, 1, 0);
      program_lines();
      offer_track(20, 0, -1, 0, 1, 3, 1'b0);
      offer_track(21, 0, -1, 0, 2, 3, 1'b0);
      offer_track(22, 0, 2, 0, -1, 3, 1'b0);
      offer_track(23, 1, -1, 1, 2, 3, 1'b0);
      drain();

      set_random_lines(8000);
      program_lines();
      run_random(300, FULL_SPAN);
      drain();

      set_lines(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX);
      program_lines();
      run_random(150, FULL_SPAN);
      drain();

      set_random_lines(5);
      program_lines();
      run_random(150, 5);
      drain();

      set_random_lines(FULL_SPAN);
      program_lines();
      hold_wanted = 1'b1;
      run_random(200, FULL_SPAN);
      drain();

      set_random_lines(8000);
      program_lines();
      run_random(220, FULL_SPAN);
      drain();

      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
